### hdl/swgfr_pkg.sv
// ----------------------------------------------------------------------------
// swgfr_pkg
// Shared types and constants for the sync-word gain frame receiver.
// ----------------------------------------------------------------------------
package swgfr_pkg;

    localparam int unsigned FRAME_LENGTH_DEF = 32;

    localparam int unsigned HDR_LEN     = 4;
    localparam int unsigned GAIN_FIRST  = 4;
    localparam int unsigned GAIN_COUNT  = 18;
    localparam int unsigned GAIN_FIELDS = 9;
    localparam int unsigned GAIN_IDX_W  = $clog2(GAIN_COUNT);

    // sync word, first byte on the wire first
    localparam logic [7:0] HEADER [HDR_LEN] = '{8'h8A, 8'h8B, 8'h1C, 8'hAE};

    typedef logic [15:0] t_gain_word;
    typedef logic [GAIN_FIELDS-1:0][15:0] t_gain_set;

    // frame tracker -> gain store / top
    typedef struct packed {
        logic                  wr_en;    // accepted byte is a gain byte
        logic [GAIN_IDX_W-1:0] wr_idx;   // gain byte slot
        logic                  at_last;  // next byte completes the frame
        logic                  done;     // accepted byte completes the frame
    } t_track;

endpackage

### hdl/swgfr_byte_if.sv
// ----------------------------------------------------------------------------
// swgfr_byte_if
// Valid/ready channel carrying one received byte per item.
// ----------------------------------------------------------------------------
interface swgfr_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

### hdl/swgfr_gain_if.sv
// ----------------------------------------------------------------------------
// swgfr_gain_if
// Valid/ready channel carrying the nine decoded gains per item.
// ----------------------------------------------------------------------------
interface swgfr_gain_if;
    logic        valid;
    logic        ready;
    logic [15:0] roll_kp;
    logic [15:0] roll_ki;
    logic [15:0] roll_kd;
    logic [15:0] pitch_kp;
    logic [15:0] pitch_ki;
    logic [15:0] pitch_kd;
    logic [15:0] yaw_kp;
    logic [15:0] yaw_ki;
    logic [15:0] yaw_kd;

    modport source (
        output valid,
        output roll_kp, output roll_ki, output roll_kd,
        output pitch_kp, output pitch_ki, output pitch_kd,
        output yaw_kp, output yaw_ki, output yaw_kd,
        input  ready
    );
    modport sink (
        input  valid,
        input  roll_kp, input roll_ki, input roll_kd,
        input  pitch_kp, input pitch_ki, input pitch_kd,
        input  yaw_kp, input yaw_ki, input yaw_kd,
        output ready
    );
endinterface

### hdl/sync_word_gain_frame_receiver_core.sv
// The item that completes a frame shows its gains in the following cycle.
// Throughput: one byte item per cycle, save the stall below; the single frame
//   tracker and gain register file take each byte that is accepted.
// A frame-ending byte waits only while the previous result is still unread.
// Reset (i_rst_n, synchronous, active low) returns to header hunt and
//   empties the result register; captured gain bytes are not cleared.
// ----------------------------------------------------------------------------
// sync_word_gain_frame_receiver_core
// Hunts for the 8A 8B 1C AE sync word, captures frame bytes 4..21 and emits
// nine big-endian 16-bit roll/pitch/yaw P/I/D gains once per frame.
// ----------------------------------------------------------------------------
module sync_word_gain_frame_receiver_core #(
    parameter int unsigned FRAME_LENGTH = swgfr_pkg::FRAME_LENGTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    swgfr_byte_if.sink    i_byte,
    swgfr_gain_if.source  o_gain
);
    swgfr_pkg::t_track    trk;
    swgfr_pkg::t_gain_set gains;
    logic                 out_valid;
    logic                 accept;

    // Bytes that do not finish a frame flow in regardless of the output side;
    // only the frame-ending byte needs the result register free (or freeing).
    assign i_byte.ready = !(trk.at_last && out_valid && !o_gain.ready);
    assign accept       = i_byte.valid && i_byte.ready;

    swgfr_frame_track #(
        .FRAME_LENGTH (FRAME_LENGTH)
    ) u_track (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (i_byte.rx_byte),
        .o_track  (trk)
    );

    swgfr_gain_store u_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_byte      (i_byte.rx_byte),
        .i_track     (trk),
        .i_out_ready (o_gain.ready),
        .o_out_valid (out_valid),
        .o_gains     (gains)
    );

    // field order: roll, pitch, yaw; each P, I, D
    assign o_gain.valid    = out_valid;
    assign o_gain.roll_kp  = gains[0];
    assign o_gain.roll_ki  = gains[1];
    assign o_gain.roll_kd  = gains[2];
    assign o_gain.pitch_kp = gains[3];
    assign o_gain.pitch_ki = gains[4];
    assign o_gain.pitch_kd = gains[5];
    assign o_gain.yaw_kp   = gains[6];
    assign o_gain.yaw_ki   = gains[7];
    assign o_gain.yaw_kd   = gains[8];

    // frame completion never overwrites an unread result
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        trk.done |-> (!out_valid || o_gain.ready))
        else $error("frame completed over an unread result");

    // a completed frame yields a result next cycle
    a_done_to_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        trk.done |=> out_valid)
        else $error("completed frame produced no result");

    // a result only appears after a completed frame
    a_valid_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(out_valid) |-> $past(trk.done))
        else $error("result appeared without a completed frame");

endmodule

### hdl/swgfr_frame_track.sv
// ----------------------------------------------------------------------------
// swgfr_frame_track
// Header hunt and frame byte position counter.
// ----------------------------------------------------------------------------
module swgfr_frame_track #(
    parameter int unsigned FRAME_LENGTH = swgfr_pkg::FRAME_LENGTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_byte,
    output swgfr_pkg::t_track o_track
);
    localparam int unsigned POS_W = $clog2(FRAME_LENGTH);
    localparam logic [POS_W-1:0] LAST_POS  = POS_W'(FRAME_LENGTH - 1);
    localparam logic [POS_W-1:0] HDR_END   = POS_W'(swgfr_pkg::HDR_LEN);
    localparam logic [POS_W-1:0] GAIN_LO   = POS_W'(swgfr_pkg::GAIN_FIRST);
    localparam logic [POS_W-1:0] GAIN_END  =
        POS_W'(swgfr_pkg::GAIN_FIRST + swgfr_pkg::GAIN_COUNT);

    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] n_pos;
    logic             in_hdr;
    logic             hdr_hit;
    logic [POS_W-1:0] gain_off;

    assign in_hdr   = (r_pos < HDR_END);
    assign hdr_hit  = (i_byte == swgfr_pkg::HEADER[r_pos[1:0]]);
    assign gain_off = r_pos - GAIN_LO;

    // next position; a header miss drops back to hunt without rechecking
    always_comb begin
        n_pos = r_pos;
        if (i_accept) begin
            if (in_hdr) begin
                n_pos = hdr_hit ? r_pos + POS_W'(1) : '0;
            end else if (r_pos == LAST_POS) begin
                n_pos = '0;
            end else begin
                n_pos = r_pos + POS_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else begin
            r_pos <= n_pos;
        end
    end

    always_comb begin
        o_track.at_last = !in_hdr && (r_pos == LAST_POS);
        o_track.done    = i_accept && o_track.at_last;
        o_track.wr_en   = i_accept && !in_hdr && (r_pos < GAIN_END);
        o_track.wr_idx  = gain_off[swgfr_pkg::GAIN_IDX_W-1:0];
    end

endmodule

### hdl/swgfr_gain_store.sv
// ----------------------------------------------------------------------------
// swgfr_gain_store
// Gain byte capture and result register.
// ----------------------------------------------------------------------------
module swgfr_gain_store (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [7:0]           i_byte,
    input  swgfr_pkg::t_track    i_track,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output swgfr_pkg::t_gain_set o_gains
);
    logic [7:0]           r_gain [swgfr_pkg::GAIN_COUNT];
    logic [7:0]           n_gain [swgfr_pkg::GAIN_COUNT];
    swgfr_pkg::t_gain_set r_res;
    swgfr_pkg::t_gain_set n_res;
    logic                 r_valid;

    always_comb begin
        n_gain = r_gain;
        if (i_track.wr_en) begin
            n_gain[i_track.wr_idx] = i_byte;
        end
    end

    // big-endian pairs; built from n_gain so a gain byte that ends the frame lands
    always_comb begin
        for (int k = 0; k < swgfr_pkg::GAIN_FIELDS; k++) begin
            n_res[k] = {n_gain[2*k], n_gain[2*k+1]};
        end
    end

    always_ff @(posedge i_clk) begin
        r_gain <= n_gain;
        if (i_track.done) begin
            r_res <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_track.done) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_valid;
    assign o_gains     = r_res;

endmodule

### bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sync-word gain frame receiver. Byte items go in
// from a queue. They are decoded alongside the block into the nine expected
// gains, and every gain item that comes out is checked against the oldest
// frame still owed. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int unsigned ITEM_TARGET  = 1250;
    localparam int unsigned IDLE_PCT     = 26;
    localparam int unsigned CALM_FIRST   = 800;     // no idling in this cycle window
    localparam int unsigned CALM_LAST    = 1200;
    localparam int unsigned TAIL_CYCLES  = 20;
    localparam int unsigned RUN_LIMIT_NS = 400000;

    logic i_clk;
    logic i_rst_n;

    swgfr_byte_if byte_ch ();
    swgfr_gain_if gain_ch ();

    sync_word_gain_frame_receiver_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (byte_ch),
        .o_gain  (gain_ch)
    );

    // decoder state, tracks the block
    int unsigned frame_pos = 0;
    logic [7:0]  gain_bytes [swgfr_pkg::GAIN_COUNT];

    logic [7:0]           byte_queue [$];
    swgfr_pkg::t_gain_set gains_due [$];
    int unsigned bytes_pushed = 0;
    int unsigned bytes_taken  = 0;
    int unsigned cycle_count  = 0;
    int unsigned errors       = 0;
    bit          last_taken   = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Advance the frame decoder by one byte; returns 1 when the frame completes.
    // A mismatch inside the sync word drops back to hunting without
    // re-examining the offending byte as a new start.
    function automatic bit decode_byte(input logic [7:0] b,
                                       output swgfr_pkg::t_gain_set gains);
        gains = '0;
        if (frame_pos < swgfr_pkg::HDR_LEN) begin
            if (b == swgfr_pkg::HEADER[frame_pos])
                frame_pos++;
            else
                frame_pos = 0;
            return 1'b0;
        end
        if (frame_pos < swgfr_pkg::GAIN_FIRST + swgfr_pkg::GAIN_COUNT)
            gain_bytes[frame_pos - swgfr_pkg::GAIN_FIRST] = b;
        frame_pos++;
        if (frame_pos < swgfr_pkg::FRAME_LENGTH_DEF)
            return 1'b0;
        frame_pos = 0;
        for (int k = 0; k < swgfr_pkg::GAIN_FIELDS; k++)
            gains[k] = {gain_bytes[2*k], gain_bytes[2*k+1]};
        return 1'b1;
    endfunction

    function automatic string gain_name(input int k);
        case (k)
            0: return "roll_kp";
            1: return "roll_ki";
            2: return "roll_kd";
            3: return "pitch_kp";
            4: return "pitch_ki";
            5: return "pitch_kd";
            6: return "yaw_kp";
            7: return "yaw_ki";
            default: return "yaw_kd";
        endcase
    endfunction

    // Sample both handshakes at the rising edge.
    always @(posedge i_clk) begin
        swgfr_pkg::t_gain_set fresh;
        swgfr_pkg::t_gain_set owed;
        swgfr_pkg::t_gain_set got;
        cycle_count++;
        last_taken = 1'b0;
        if (i_rst_n) begin
            if (byte_ch.valid && byte_ch.ready) begin
                last_taken = 1'b1;
                bytes_taken++;
                if (decode_byte(byte_ch.rx_byte, fresh))
                    gains_due.push_back(fresh);
            end
            if (gain_ch.valid && gain_ch.ready) begin
                got = {gain_ch.yaw_kd, gain_ch.yaw_ki, gain_ch.yaw_kp,
                       gain_ch.pitch_kd, gain_ch.pitch_ki, gain_ch.pitch_kp,
                       gain_ch.roll_kd, gain_ch.roll_ki, gain_ch.roll_kp};
                if (gains_due.size() == 0) begin
                    $error("gain item with no completed frame pending");
                    errors++;
                end else begin
                    owed = gains_due.pop_front();
                    for (int k = 0; k < swgfr_pkg::GAIN_FIELDS; k++) begin
                        if (got[k] !== owed[k]) begin
                            $error("%s: expected %h, got %h", gain_name(k), owed[k], got[k]);
                            errors++;
                        end
                    end
                end
            end
        end
    end

    // Drive both channels at the falling edge.
    always @(negedge i_clk) begin
        bit calm;
        calm = (cycle_count >= CALM_FIRST) && (cycle_count < CALM_LAST);
        gain_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        if (!i_rst_n) begin
            byte_ch.valid <= 1'b0;
        end else if (!byte_ch.valid || last_taken) begin
            if (byte_queue.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
                byte_ch.valid   <= 1'b1;
                byte_ch.rx_byte <= byte_queue.pop_front();
            end else begin
                byte_ch.valid   <= 1'b0;
                byte_ch.rx_byte <= 8'($urandom);
            end
        end
    end

    task automatic push_byte(input logic [7:0] b);
        byte_queue.push_back(b);
        bytes_pushed++;
    endtask

    // Payload leans on the edges and on sync-word values.
    function automatic logic [7:0] payload_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            2: return swgfr_pkg::HEADER[$urandom_range(0, swgfr_pkg::HDR_LEN - 1)];
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic push_frame();
        for (int i = 0; i < swgfr_pkg::HDR_LEN; i++)
            push_byte(swgfr_pkg::HEADER[i]);
        for (int i = swgfr_pkg::HDR_LEN; i < swgfr_pkg::FRAME_LENGTH_DEF; i++)
            push_byte(payload_byte());
    endtask

    // Hold off until every byte is in and every frame has come out.
    task automatic drain();
        while (bytes_taken != bytes_pushed || gains_due.size() != 0)
            @(negedge i_clk);
    endtask

    initial begin
        int unsigned pick;
        int unsigned len;
        logic [7:0]  wrong;
        logic [15:0] extreme [swgfr_pkg::GAIN_FIELDS];

        extreme = '{16'h0000, 16'hFFFF, 16'h8001, 16'h7FFE, 16'h8A8B,
                    16'h1CAE, 16'h0001, 16'hFF00, 16'h00FF};
        i_rst_n         = 1'b0;
        byte_ch.valid   = 1'b0;
        byte_ch.rx_byte = 8'h00;
        gain_ch.ready   = 1'b0;

        // hunting drops anything but the first sync byte
        push_byte(8'h00); push_byte(8'hFF); push_byte(8'h8B); push_byte(8'hAE);
        // sync word broken at each later position
        push_byte(8'h8A); push_byte(8'h00);
        push_byte(8'h8A); push_byte(8'h8B); push_byte(8'hFF);
        // a first sync byte in the last slot is not taken as a new start
        push_byte(8'h8A); push_byte(8'h8B); push_byte(8'h1C);
        push_byte(8'h8A); push_byte(8'h8B); push_byte(8'h1C); push_byte(8'hAE);
        push_byte(8'h8A); push_byte(8'h8A); push_byte(8'h8B); push_byte(8'h1C);
        push_byte(8'hAE);
        // full frame with edge gains, sync-looking tail, then back to back
        for (int i = 0; i < swgfr_pkg::HDR_LEN; i++)
            push_byte(swgfr_pkg::HEADER[i]);
        for (int k = 0; k < swgfr_pkg::GAIN_FIELDS; k++) begin
            push_byte(extreme[k][15:8]);
            push_byte(extreme[k][7:0]);
        end
        for (int i = swgfr_pkg::GAIN_FIRST + swgfr_pkg::GAIN_COUNT;
             i < swgfr_pkg::FRAME_LENGTH_DEF; i++)
            push_byte(swgfr_pkg::HEADER[i % swgfr_pkg::HDR_LEN]);
        push_frame();

        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // sender stays quiet until the directed frames are all out
        drain();

        while (bytes_pushed < ITEM_TARGET) begin
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
                push_frame();
            end else if (pick < 88) begin
                len = $urandom_range(1, swgfr_pkg::HDR_LEN - 1);
                for (int i = 0; i < len; i++)
                    push_byte(swgfr_pkg::HEADER[i]);
                do
                    wrong = 8'($urandom);
                while (wrong == swgfr_pkg::HEADER[len]);
                push_byte(wrong);
            end else begin
                repeat ($urandom_range(1, 4))
                    push_byte(8'($urandom));
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (errors == 0 && gains_due.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("status: fail");
        $finish;
    end

endmodule
